// ===== sv/k_nearest_point_select_defines.svh =====
// ----------------------------------------------------------------------------
// k_nearest_point_select_defines.svh
// Assertion macros for the k nearest point selector. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef K_NEAREST_POINT_SELECT_DEFINES_SVH
`define K_NEAREST_POINT_SELECT_DEFINES_SVH

`ifndef SYNTHESIS
// condition must hold on every edge outside reset
`define KNPS_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("knps: check failed");
// antecedent in one cycle implies the consequent in the next
`define KNPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("knps: sequence check failed");
`else
`define KNPS_ASSERT(label, cond)
`define KNPS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/knps_pkg.sv =====
// ----------------------------------------------------------------------------
// knps_pkg
// Shared word types and command codes of the k nearest point selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package knps_pkg;

  // command codes
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // neighbour count after reset
  localparam logic [6:0] NBR_RESET = 7'd20;

  // input word
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [31:0] response_in;
  } cmd_word_t;

  // result word
  typedef struct packed {
    logic [7:0]  point_index;
    logic [31:0] response_out;
    logic [32:0] distance_sq;
    logic        found;
    logic        last;
  } res_word_t;

endpackage

// ===== sv/k_nearest_point_select.sv =====
// ----------------------------------------------------------------------------
// k_nearest_point_select
// Keeps a store of 2-D points with response words and returns the k nearest
// stored points to a query point, nearest first, ties to the lower index.
// ----------------------------------------------------------------------------
//  channel   | ports                        | handshake
//  ----------+------------------------------+-------------------------------
//  command   | start, busy, cmd_word        | taken when start & !busy
//  result    | res_strobe, res_word         | one-cycle strobe per word, no stall
//  config    | cfg_we, cfg_data             | written when cfg_we is high
//
// Clear and append leave the selector idle. An empty-store query goes through
// ST_EMPTY, which registers its not-found word and strobe. Otherwise a query
// makes min(k, count) passes over the store through one shared distance unit
// and comparator; each pass reads one point per cycle, drains the pipeline
// and emits one strobed word. Busy falls with the last word. Reset is
// synchronous, clears the count and sets k to 20. Results cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "k_nearest_point_select_defines.svh"

module k_nearest_point_select
  import knps_pkg::*;
#(
  parameter int MAX_POINTS    = 256,
  parameter int MAX_NEIGHBORS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  cmd_word_t cmd_word,
  output logic      res_strobe,
  output res_word_t res_word,
  input  logic      cfg_we,
  input  logic [6:0] cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;
  localparam int KW = 33 + AW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_EMIT, ST_EMPTY
  } state_t;

  state_t        state;
  logic [6:0]    neighbor_count;
  logic [CW-1:0] point_count;
  logic [15:0]   qx, qy;
  logic [6:0]    nres, rcnt;
  logic [AW-1:0] addr;
  logic          have_prev, have_best;
  logic [KW-1:0] prev_key, best_key;
  logic [31:0]   best_resp;

  // point store and its read register
  logic [63:0]   mem [MAX_POINTS];
  logic [63:0]   rd_data;
  logic          rd_v;
  logic [AW-1:0] rd_idx;

  logic          cand_valid, dist_active;
  logic [AW-1:0] cand_idx;
  logic [32:0]   cand_dist;
  logic [31:0]   cand_resp;
  logic [KW-1:0] cand_key;
  logic          take;

  logic          accept;
  logic          store_full;
  logic [6:0]    keff;
  logic [CW+6:0] keff_w, count_w;
  logic [6:0]    nres_next;
  logic [AW+7:0] idx_ext;

  assign accept     = start && (state == ST_IDLE);
  assign busy       = (state != ST_IDLE);
  assign store_full = (point_count >= CW'(MAX_POINTS));

  // effective k and number of results for a query
  always_comb begin
    if (neighbor_count == 7'd0) begin
      keff = 7'd1;
    end else if (neighbor_count > 7'(MAX_NEIGHBORS)) begin
      keff = 7'(MAX_NEIGHBORS);
    end else begin
      keff = neighbor_count;
    end
    keff_w    = {{CW{1'b0}}, keff};
    count_w   = {7'd0, point_count};
    nres_next = (keff_w < count_w) ? keff : count_w[6:0];
  end

  // store write and read ports
  always_ff @(posedge clk) begin
    if (accept && cmd_word.func == FUNC_APPEND && !store_full) begin
      mem[point_count[AW-1:0]] <= {cmd_word.coord_x, cmd_word.coord_y,
                                   cmd_word.response_in};
    end
    rd_data <= mem[addr];
    rd_idx  <= addr;
  end

  knps_dist #(.IW(AW)) u_dist (
    .clk        (clk),
    .rst        (rst),
    .pt_valid   (rd_v),
    .pt_idx     (rd_idx),
    .pt_x       (rd_data[63:48]),
    .pt_y       (rd_data[47:32]),
    .pt_resp    (rd_data[31:0]),
    .q_x        (qx),
    .q_y        (qy),
    .cand_valid (cand_valid),
    .cand_idx   (cand_idx),
    .cand_dist  (cand_dist),
    .cand_resp  (cand_resp),
    .active     (dist_active)
  );

  // candidate must rank after the last emitted point and before the best so far
  always_comb begin
    cand_key = {cand_dist, cand_idx};
    take     = cand_valid && (!have_prev || cand_key > prev_key)
                          && (!have_best || cand_key < best_key);
    idx_ext  = {8'd0, best_key[AW-1:0]};
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      res_strobe     <= 1'b0;
      neighbor_count <= NBR_RESET;
      point_count    <= '0;
      rd_v           <= 1'b0;
      have_prev      <= 1'b0;
      have_best      <= 1'b0;
      addr           <= '0;
      rcnt           <= '0;
      nres           <= '0;
    end else begin
      res_strobe <= (state == ST_EMIT) || (state == ST_EMPTY);
      rd_v       <= (state == ST_SCAN);
      if (cfg_we) begin
        neighbor_count <= cfg_data;
      end
      if (take) begin
        have_best <= 1'b1;
        best_key  <= cand_key;
        best_resp <= cand_resp;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd_word.func)
              FUNC_CLEAR: begin
                point_count <= '0;
              end
              FUNC_APPEND: begin
                if (!store_full) begin
                  point_count <= point_count + 1'b1;
                end
              end
              FUNC_QUERY: begin
                qx        <= cmd_word.coord_x;
                qy        <= cmd_word.coord_y;
                nres      <= nres_next;
                rcnt      <= '0;
                addr      <= '0;
                have_prev <= 1'b0;
                have_best <= 1'b0;
                state     <= (point_count == '0) ? ST_EMPTY : ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if ({1'b0, addr} == CW'(point_count - 1'b1)) begin
            state <= ST_DRAIN;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!rd_v && !dist_active) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          res_word.point_index  <= idx_ext[7:0];
          res_word.response_out <= best_resp;
          res_word.distance_sq  <= best_key[KW-1:AW];
          res_word.found        <= 1'b1;
          res_word.last         <= (rcnt == nres - 1'b1);
          prev_key              <= best_key;
          have_prev             <= 1'b1;
          have_best             <= 1'b0;
          rcnt                  <= rcnt + 1'b1;
          addr                  <= '0;
          state                 <= (rcnt == nres - 1'b1) ? ST_IDLE : ST_SCAN;
        end
        ST_EMPTY: begin
          res_word.point_index  <= 8'd0;
          res_word.response_out <= 32'd0;
          res_word.distance_sq  <= 33'd0;
          res_word.found        <= 1'b0;
          res_word.last         <= 1'b1;
          state                 <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `KNPS_ASSERT(a_last_frees, !res_strobe || (res_word.last != busy))
  `KNPS_ASSERT(a_notfound_last, !res_strobe || res_word.found || res_word.last)
  `KNPS_ASSERT_NEXT(a_query_busy, accept && cmd_word.func == FUNC_QUERY, busy)
  `KNPS_ASSERT(a_scan_addr, state != ST_SCAN || CW'(addr) < point_count)
  `KNPS_ASSERT(a_emit_best, state != ST_EMIT || have_best)

endmodule

// ===== sv/knps_dist.sv =====
// ----------------------------------------------------------------------------
// knps_dist
// Three-stage squared distance unit: absolute differences, squares, sum.
// One stored point enters per cycle; its tag and response travel alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module knps_dist #(
  parameter int IW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pt_valid,
  input  logic [IW-1:0] pt_idx,
  input  logic [15:0]   pt_x,
  input  logic [15:0]   pt_y,
  input  logic [31:0]   pt_resp,
  input  logic [15:0]   q_x,
  input  logic [15:0]   q_y,
  output logic          cand_valid,
  output logic [IW-1:0] cand_idx,
  output logic [32:0]   cand_dist,
  output logic [31:0]   cand_resp,
  output logic          active
);

  logic          s1_v, s2_v;
  logic [IW-1:0] s1_idx, s2_idx;
  logic [31:0]   s1_resp, s2_resp;
  logic [15:0]   s1_dx, s1_dy;
  logic [31:0]   sq_x, sq_y;
  logic [15:0]   dx_next, dy_next;

  // absolute differences
  always_comb begin
    dx_next = (pt_x >= q_x) ? (pt_x - q_x) : (q_x - pt_x);
    dy_next = (pt_y >= q_y) ? (pt_y - q_y) : (q_y - pt_y);
  end

  // valid tags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      cand_valid <= 1'b0;
    end else begin
      s1_v       <= pt_valid;
      s2_v       <= s1_v;
      cand_valid <= s2_v;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    s1_dx     <= dx_next;
    s1_dy     <= dy_next;
    s1_idx    <= pt_idx;
    s1_resp   <= pt_resp;
    sq_x      <= 32'(s1_dx) * 32'(s1_dx);
    sq_y      <= 32'(s1_dy) * 32'(s1_dy);
    s2_idx    <= s1_idx;
    s2_resp   <= s1_resp;
    cand_dist <= {1'b0, sq_x} + {1'b0, sq_y};
    cand_idx  <= s2_idx;
    cand_resp <= s2_resp;
  end

  assign active = s1_v | s2_v | cand_valid;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the k nearest point selector. A short table of
// directed commands (empty store, unused code, extreme coordinates, ties,
// clear) is followed by a random fill of the store up to full, with queries
// under several neighbour counts and two dropped appends at the end. Every
// query is predicted in the bench and each result word is checked field by
// field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import knps_pkg::*;
();

  localparam int MAX_PTS   = 256;
  localparam int MAX_NBR   = 64;
  localparam int LIMIT     = 20_000_000;
  localparam int N_DIR     = 17;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam res_word_t NOT_FOUND = res_word_t'({8'd0, 32'd0, 33'd0, 1'b0, 1'b1});

  typedef struct {
    cmd_word_t cmd;
    bit        typed;
    res_word_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      start;
  logic      busy;
  cmd_word_t cmd_word;
  logic      res_strobe;
  res_word_t res_word;
  logic      cfg_we;
  logic [6:0] cfg_data;

  // predictor state
  logic [15:0] pt_x    [MAX_PTS];
  logic [15:0] pt_y    [MAX_PTS];
  logic [31:0] pt_resp [MAX_PTS];
  int          n_pts;
  logic [6:0]  k_setting;

  res_word_t neighbour_q[$];
  int        mismatches;
  int        cycles;
  bit        no_gaps;
  dir_row_t  dir_tab [N_DIR];

  k_nearest_point_select uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd_word   (cmd_word),
    .res_strobe (res_strobe),
    .res_word   (res_word),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // add one expected word at the tail of the queue
  function automatic void queue_word(input res_word_t w);
    neighbour_q.insert(neighbour_q.size(), w);
  endfunction

  // update the point store and queue the neighbour words a command gives
  function automatic void apply_command(input cmd_word_t c);
    logic [32:0] best_d [MAX_NBR];
    int          best_i [MAX_NBR];
    int          filled, pos, top, kk;
    logic [15:0] dx, dy;
    logic [32:0] d;
    res_word_t   w;
    case (c.func)
      FUNC_CLEAR: n_pts = 0;
      FUNC_APPEND: begin
        if (n_pts < MAX_PTS) begin
          pt_x[n_pts]    = c.coord_x;
          pt_y[n_pts]    = c.coord_y;
          pt_resp[n_pts] = c.response_in;
          n_pts++;
        end
      end
      FUNC_QUERY: begin
        if (n_pts == 0) begin
          queue_word(NOT_FOUND);
        end else begin
          kk = (k_setting == 0) ? 1 : (k_setting > MAX_NBR) ? MAX_NBR : int'(k_setting);
          filled = 0;
          // insertion into a sorted list; strict compare keeps lower index first
          for (int i = 0; i < n_pts; i++) begin
            dx = (pt_x[i] >= c.coord_x) ? pt_x[i] - c.coord_x : c.coord_x - pt_x[i];
            dy = (pt_y[i] >= c.coord_y) ? pt_y[i] - c.coord_y : c.coord_y - pt_y[i];
            d  = 33'(dx) * 33'(dx) + 33'(dy) * 33'(dy);
            pos = filled;
            while (pos > 0 && d < best_d[pos-1]) pos--;
            if (pos < kk) begin
              top = (filled < kk) ? filled : kk - 1;
              for (int j = top; j > pos; j--) begin
                best_d[j] = best_d[j-1];
                best_i[j] = best_i[j-1];
              end
              best_d[pos] = d;
              best_i[pos] = i;
              if (filled < kk) filled++;
            end
          end
          for (int r = 0; r < filled; r++) begin
            w.point_index  = 8'(best_i[r]);
            w.response_out = pt_resp[best_i[r]];
            w.distance_sq  = best_d[r];
            w.found        = 1'b1;
            w.last         = (r == filled - 1);
            queue_word(w);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic dir_row_t row(input logic [1:0] f, input logic [15:0] x,
                                   input logic [15:0] y, input logic [31:0] r,
                                   input bit t, input res_word_t e);
    dir_row_t dr;
    dr.cmd.func        = f;
    dr.cmd.coord_x     = x;
    dr.cmd.coord_y     = y;
    dr.cmd.response_in = r;
    dr.typed           = t;
    dr.want            = e;
    return dr;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // coordinates biased towards the edges and towards repeats, so ties occur
  function automatic logic [15:0] pick_coord(input logic [15:0] prev);
    case ($urandom_range(0, 4))
      0: return prev;
      1: return 16'($urandom_range(0, 7));
      2: return 16'hFFFF - 16'($urandom_range(0, 7));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // hand one command word over; returns at the falling edge after acceptance
  // with start still high, so the caller either drives the next word or drops it
  task automatic send_cmd(input cmd_word_t w, input bit typed, input res_word_t tw);
    int gap;
    int qsz;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    = 1'b1;
    cmd_word = w;
    do @(posedge clk); while (busy);
    qsz = neighbour_q.size();
    apply_command(w);
    if (typed) begin
      while (neighbour_q.size() > qsz) void'(neighbour_q.pop_back());
      queue_word(tw);
    end
    @(negedge clk);
  endtask

  task automatic send_rand(input logic [1:0] f, input logic [15:0] x, input logic [15:0] y);
    cmd_word_t w;
    w.func        = f;
    w.coord_x     = x;
    w.coord_y     = y;
    w.response_in = $urandom;
    send_cmd(w, 1'b0, NOT_FOUND);
  endtask

  // drain everything in flight, then write k
  task automatic write_k(input logic [6:0] v);
    start = 1'b0;
    while (neighbour_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_data  = v;
    k_setting = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    res_word_t e;
    if (!rst && res_strobe) begin
      if (neighbour_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: idx=%0d resp=%h dist=%h found=%b last=%b",
                   res_word.point_index, res_word.response_out, res_word.distance_sq,
                   res_word.found, res_word.last);
      end else begin
        e = neighbour_q.pop_front();
        if (res_word.point_index !== e.point_index || res_word.response_out !== e.response_out
            || res_word.distance_sq !== e.distance_sq || res_word.found !== e.found
            || res_word.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("word mismatch: expected idx=%0d resp=%h dist=%h found=%b last=%b",
                     e.point_index, e.response_out, e.distance_sq, e.found, e.last);
            $display("               got      idx=%0d resp=%h dist=%h found=%b last=%b",
                     res_word.point_index, res_word.response_out, res_word.distance_sq,
                     res_word.found, res_word.last);
          end
        end
      end
    end
  end

  initial begin
    logic [15:0] lx, ly;
    logic [6:0]  k_plan [6];
    rst        = 1'b1;
    start      = 1'b0;
    cmd_word   = '0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    mismatches = 0;
    cycles     = 0;
    no_gaps    = 1'b0;
    n_pts      = 0;
    k_setting  = NBR_RESET;

    // directed rows; expected words typed in where obvious
    dir_tab[0]  = row(FUNC_QUERY,  16'h1234, 16'h5678, 32'h0, 1, NOT_FOUND);
    dir_tab[1]  = row(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, NOT_FOUND);
    dir_tab[2]  = row(FUNC_QUERY,  16'h0000, 16'h0000, 32'h0, 1, NOT_FOUND);
    dir_tab[3]  = row(FUNC_APPEND, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 0, NOT_FOUND);
    dir_tab[4]  = row(FUNC_QUERY,  16'hFFFF, 16'hFFFF, 32'h0, 1,
                      res_word_t'({8'd0, 32'hFFFF_FFFF, 33'h1_FFFC_0002, 1'b1, 1'b1}));
    dir_tab[5]  = row(FUNC_QUERY,  16'h0000, 16'h0000, 32'h0, 1,
                      res_word_t'({8'd0, 32'hFFFF_FFFF, 33'h0, 1'b1, 1'b1}));
    dir_tab[6]  = row(FUNC_APPEND, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 0, NOT_FOUND);
    dir_tab[7]  = row(FUNC_APPEND, 16'h0000, 16'h0000, 32'h0000_0001, 0, NOT_FOUND);
    dir_tab[8]  = row(FUNC_APPEND, 16'h0010, 16'h0000, 32'hA5A5_A5A5, 0, NOT_FOUND);
    dir_tab[9]  = row(FUNC_QUERY,  16'h0000, 16'h0000, 32'h0, 0, NOT_FOUND);
    dir_tab[10] = row(FUNC_QUERY,  16'hFFFF, 16'h0000, 32'h0, 0, NOT_FOUND);
    dir_tab[11] = row(FUNC_CLEAR,  16'h0000, 16'h0000, 32'h0, 0, NOT_FOUND);
    dir_tab[12] = row(FUNC_QUERY,  16'h0000, 16'h0000, 32'h0, 1, NOT_FOUND);
    dir_tab[13] = row(FUNC_APPEND, 16'h8000, 16'h8000, 32'h5A5A_5A5A, 0, NOT_FOUND);
    dir_tab[14] = row(FUNC_APPEND, 16'h7FFF, 16'h8001, 32'h1234_5678, 0, NOT_FOUND);
    dir_tab[15] = row(FUNC_QUERY,  16'h8000, 16'h8000, 32'h0, 0, NOT_FOUND);
    dir_tab[16] = row(FUNC_QUERY,  16'h7FFF, 16'h7FFF, 32'h0, 0, NOT_FOUND);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < N_DIR; r++)
      send_cmd(dir_tab[r].cmd, dir_tab[r].typed, dir_tab[r].want);

    // fill the store to full with queries under several neighbour counts,
    // extremes included; the last two appends are dropped and k saturates
    k_plan[0] = 7'd0;
    k_plan[1] = 7'd1;
    k_plan[2] = 7'd64;
    k_plan[3] = 7'($urandom_range(2, 63));
    k_plan[4] = 7'($urandom_range(65, 126));
    k_plan[5] = 7'd127;
    write_k(k_plan[0]);
    send_rand(FUNC_CLEAR, 16'($urandom), 16'($urandom));
    lx = 16'h8000;
    ly = 16'h8000;
    for (int a = 0; a < MAX_PTS + 2; a++) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      lx = pick_coord(lx);
      ly = pick_coord(ly);
      send_rand(FUNC_APPEND, lx, ly);
      if (a % 43 == 42) begin
        send_rand(FUNC_QUERY, pick_coord(lx), pick_coord(ly));
        if (a / 43 < 5)
          write_k(k_plan[a / 43 + 1]);
      end
    end
    start = 1'b0;

    // drain and settle
    while (neighbour_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    mismatches += neighbour_q.size();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
